// ===== src/afdl_pkg.sv =====
// Shared constants and types of the audio frame delay line.
package afdl_pkg;

	localparam int MAX_FRAME_BYTES  = 256;
	localparam int MAX_DELAY_FRAMES = 64;
	localparam int EXTRA_FRAMES     = 64;
	localparam int STORE_SLOTS      = MAX_DELAY_FRAMES + EXTRA_FRAMES;
	localparam int POS_W            = $clog2(MAX_FRAME_BYTES);
	localparam int SLOT_W           = $clog2(STORE_SLOTS);
	localparam int ADDR_W           = SLOT_W + POS_W;
	localparam int STORE_DEPTH      = STORE_SLOTS * MAX_FRAME_BYTES;

	localparam int BYTE_W     = 8;
	localparam int MODE_W     = 2;
	localparam int DELAY_W    = 7;
	localparam int FBYTES_W   = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MUTE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PTR_RST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FBYTES = 1'd1;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic              valid;
		logic              fwd;
		logic [BYTE_W-1:0] fwd_byte;
		logic              frame_end;
	} push_t;

	typedef struct packed {
		logic clearing;
		logic muting;
	} ctrl_stat_t;

endpackage

// ===== src/afdl_ifs.sv =====
// Channel interfaces of the audio frame delay line.
interface afdl_in_if
	import afdl_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [BYTE_W-1:0]     in_byte;
	logic [DELAY_W-1:0]    mute_count;

	modport source(output valid, mode, in_byte, mute_count, input ready);
	modport sink(input valid, mode, in_byte, mute_count, output ready);
endinterface

interface afdl_out_if
	import afdl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              frame_end;

	modport source(output valid, out_byte, frame_end, input ready);
	modport sink(input valid, out_byte, frame_end, output ready);
endinterface

interface afdl_cfg_if
	import afdl_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/afdl_store.sv =====
// Frame store: one write port, one read port with registered read data.
module afdl_store
	import afdl_pkg::*;
(
	input  logic              clk,
	input  mem_wr_t           wr,
	input  mem_rd_t           rd,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/afdl_ctrl.sv =====
// Ring pointers, configuration and the clear and mute sequencer.
module afdl_ctrl
	import afdl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	afdl_in_if.sink      din,
	afdl_cfg_if.sink     cfg,
	input  logic         res_free,
	output mem_wr_t      wr,
	output mem_rd_t      rd,
	output push_t        push,
	output ctrl_stat_t   stat
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_MUTE  = 2'd2;

	logic [1:0]          state_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [FBYTES_W-1:0] fbytes_q;
	logic [SLOT_W-1:0]   wf_q;
	logic [SLOT_W-1:0]   rf_q;
	logic [POS_W-1:0]    pos_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [SLOT_W-1:0]   mslot_q;
	logic [POS_W-1:0]    mpos_q;
	logic [DELAY_W-1:0]  mleft_q;

	logic                in_acc;
	logic                cfg_acc;
	logic [SLOT_W-1:0]   last_slot;
	logic                push_end;
	logic                mute_end;
	logic [DELAY_W-1:0]  dly_new;
	logic [FBYTES_W-1:0] fb_new;
	logic [DELAY_W-1:0]  mute_n;
	logic [SLOT_W-1:0]   wf_prev;

	assign cfg.ready = 1'b1;
	assign din.ready = (state_q == ST_RUN) && res_free;
	assign in_acc    = din.valid && din.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;

	assign last_slot = SLOT_W'(delay_q) + SLOT_W'(EXTRA_FRAMES - 1);
	assign wf_prev   = (wf_q == '0) ? last_slot : wf_q - SLOT_W'(1);
	assign push_end  = ({1'b0, pos_q} + FBYTES_W'(1)) >= fbytes_q;
	assign mute_end  = ({1'b0, mpos_q} + FBYTES_W'(1)) >= fbytes_q;
	assign mute_n    = (din.mute_count >= delay_q) ? delay_q - DELAY_W'(1) : din.mute_count;

	always_comb begin
		if (cfg.data[DELAY_W-1:0] == '0) begin
			dly_new = DELAY_W'(1);
		end else if (cfg.data[DELAY_W-1:0] > DELAY_W'(MAX_DELAY_FRAMES)) begin
			dly_new = DELAY_W'(MAX_DELAY_FRAMES);
		end else begin
			dly_new = cfg.data[DELAY_W-1:0];
		end
		if (cfg.data == '0) begin
			fb_new = FBYTES_W'(1);
		end else if (cfg.data > CFG_DATA_W'(MAX_FRAME_BYTES)) begin
			fb_new = FBYTES_W'(MAX_FRAME_BYTES);
		end else begin
			fb_new = cfg.data;
		end
	end

	always_comb begin
		wr.we   = 1'b0;
		wr.addr = {wf_q, pos_q};
		wr.data = din.in_byte;
		case (state_q)
			ST_CLEAR: begin
				wr.we   = 1'b1;
				wr.addr = clr_q;
				wr.data = '0;
			end
			ST_MUTE: begin
				wr.we   = 1'b1;
				wr.addr = {mslot_q, mpos_q};
				wr.data = '0;
			end
			ST_RUN: begin
				wr.we = in_acc && (din.mode == MODE_PUSH);
			end
			default: begin
				wr.we = 1'b0;
			end
		endcase
	end

	assign rd.re   = in_acc && (din.mode == MODE_PUSH);
	assign rd.addr = {rf_q, pos_q};

	assign push.valid     = in_acc && (din.mode == MODE_PUSH);
	assign push.fwd       = (wf_q == rf_q);
	assign push.fwd_byte  = din.in_byte;
	assign push.frame_end = push_end;

	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.muting   = (state_q == ST_MUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			delay_q  <= DELAY_W'(1);
			fbytes_q <= FBYTES_W'(MAX_FRAME_BYTES);
			wf_q     <= '0;
			rf_q     <= '0;
			pos_q    <= '0;
			clr_q    <= '0;
			mslot_q  <= '0;
			mpos_q   <= '0;
			mleft_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_MUTE: begin
					if (mute_end) begin
						mpos_q  <= '0;
						mslot_q <= (mslot_q == '0) ? last_slot : mslot_q - SLOT_W'(1);
						mleft_q <= mleft_q - DELAY_W'(1);
						if (mleft_q == DELAY_W'(1)) begin
							state_q <= ST_RUN;
						end
					end else begin
						mpos_q <= mpos_q + POS_W'(1);
					end
				end
				ST_RUN: begin
					if (in_acc) begin
						case (din.mode)
							MODE_PUSH: begin
								if (push_end) begin
									wf_q  <= (wf_q == last_slot) ? '0 : wf_q + SLOT_W'(1);
									rf_q  <= (rf_q == last_slot) ? '0 : rf_q + SLOT_W'(1);
									pos_q <= '0;
								end else begin
									pos_q <= pos_q + POS_W'(1);
								end
							end
							MODE_MUTE: begin
								if (mute_n != '0) begin
									state_q <= ST_MUTE;
									mslot_q <= wf_prev;
									mpos_q  <= '0;
									mleft_q <= mute_n;
								end
							end
							MODE_PTR_RST: begin
								wf_q  <= SLOT_W'(delay_q - DELAY_W'(1));
								rf_q  <= '0;
								pos_q <= '0;
							end
							default: begin
								pos_q <= pos_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
			if (cfg_acc) begin
				case (cfg.index)
					REG_DELAY: begin
						delay_q <= dly_new;
						wf_q    <= SLOT_W'(dly_new - DELAY_W'(1));
						rf_q    <= '0;
						pos_q   <= '0;
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end
					REG_FBYTES: begin
						fbytes_q <= fb_new;
					end
					default: begin
						fbytes_q <= fbytes_q;
					end
				endcase
			end
		end
	end

endmodule

// ===== src/audio_frame_delay_line.sv =====
// Top level of the audio frame delay line: store, controller and result stage.
//
//  channel | dir | beat fields                     | accepted when
//  din     | in  | mode, in_byte, mute_count       | din.valid & din.ready
//  dout    | out | out_byte, frame_end             | dout.valid & dout.ready
//  cfg     | in  | index, data                     | cfg.valid & cfg.ready
//
// Pushes stream one per cycle while din.ready is high, via read stage and output register.
// Mute of n frames (capped at delay - 1) holds din.ready low, one store write per byte.
// Reset and each delay_frames write clear all 32768 store bytes, one byte a cycle.
// Pointer reset and unused mode give no result.
// A stalled dout holds one result in the output register and one in the read stage.
module audio_frame_delay_line
	import afdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	afdl_in_if.sink     din,
	afdl_out_if.source  dout,
	afdl_cfg_if.sink    cfg
);

	mem_wr_t           wr;
	mem_rd_t           rd;
	push_t             push;
	ctrl_stat_t        stat;
	logic [BYTE_W-1:0] rd_data;

	logic              s1_v_s1;
	logic              fwd_s1;
	logic [BYTE_W-1:0] fwd_byte_s1;
	logic              end_s1;
	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              frame_end_q;
	logic              s1_adv;
	logic              res_free;

	afdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.cfg      (cfg),
		.res_free (res_free),
		.wr       (wr),
		.rd       (rd),
		.push     (push),
		.stat     (stat)
	);

	afdl_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign s1_adv   = s1_v_s1 && (!out_v_q || dout.ready);
	assign res_free = !s1_v_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (push.valid) begin
				s1_v_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			fwd_s1      <= push.fwd;
			fwd_byte_s1 <= push.fwd_byte;
			end_s1      <= push.frame_end;
		end
		if (s1_adv) begin
			out_byte_q  <= fwd_s1 ? fwd_byte_s1 : rd_data;
			frame_end_q <= end_s1;
		end
	end

	assign dout.valid     = out_v_q;
	assign dout.out_byte  = out_byte_q;
	assign dout.frame_end = frame_end_q;

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.clearing || stat.muting) |-> !din.ready)
		else $error("input taken during clear or mute");

	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_s1 && !s1_adv) |-> !push.valid)
		else $error("pending read result overwritten");

	a_delay_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready && cfg.index == REG_DELAY) |=> stat.clearing)
		else $error("delay write did not start clearing pass");

endmodule
